@@ hdl/frars_pkg.sv @@
// shared constants for the fenwick range-add / range-sum block
`default_nettype none

package frars_pkg;

    localparam int IDX_W    = 11;
    localparam int DATA_W   = 32;
    localparam int DEF_SIZE = 1024;

    // slave tdata: first_index, last_index, amount, then zero fill to whole bytes
    localparam int S_FIELDS_W = 2 * IDX_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = DATA_W;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

endpackage

`default_nettype wire

@@ hdl/fenwick_range_add_range_sum.sv @@
// Range add and range sum over 1..SIZE with two binary indexed trees in block memories.
// Reset starts a clearing pass that zeroes both trees, one entry a cycle, with
// s_axis_tready low. An add runs two update walks and a sum two prefix walks, each walk
// visiting at most log2(SIZE)+1 tree nodes. The read-modify-write on each tree memory
// sets the pace; one command is in flight at a time, and a finished sum waits in ST_Q_SUM
// only while an earlier result still sits undrained in the output register.
`default_nettype none

module fenwick_range_add_range_sum
    import frars_pkg::*;
#(
    parameter int SIZE = DEF_SIZE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // first_index[10:0], last_index[21:11], amount[53:22], zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]           s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // range_sum[31:0]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int PW = ((AW > IDX_W) ? AW : IDX_W) + 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_MUL,
        ST_POST_RD,
        ST_POST_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_MUL,
        ST_Q_SUM
    } state_t;

    state_t state_reg, state_next;

    logic               phase_reg, phase_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [DATA_W-1:0]  amount_reg, amount_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      cx_reg, cx_next;
    logic [DATA_W-1:0]  delta_b_reg, delta_b_next;
    logic [DATA_W-1:0]  delta_c_reg, delta_c_next;
    logic [DATA_W-1:0]  acc_b_reg, acc_b_next;
    logic [DATA_W-1:0]  acc_c_reg, acc_c_next;
    logic [DATA_W-1:0]  prod_reg, prod_next;
    logic [DATA_W-1:0]  pre_reg, pre_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [AW-1:0]      clr_reg, clr_next;

    // tree memories
    logic [DATA_W-1:0]  base_mem [SIZE];
    logic [DATA_W-1:0]  corr_mem [SIZE];
    logic [DATA_W-1:0]  rd_b_reg, rd_c_reg;

    logic               mem_rd_en;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_addr;
    logic [AW-1:0]      mem_wr_addr;
    logic [DATA_W-1:0]  mem_wr_b, mem_wr_c;

    // shared multiplier
    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [2*DATA_W-1:0] mul_full;

    logic               s_accept;
    logic [IDX_W-1:0]   in_first, in_last;
    logic [DATA_W-1:0]  in_amount;
    logic [IDX_W-1:0]   x_sel;
    logic [PW-1:0]      x_clamped;
    logic [PW-1:0]      low_bit;
    logic               pos_out;
    logic [DATA_W-1:0]  prefix;
    logic               out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_first  = s_axis_tdata[IDX_W-1:0];
    assign in_last   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_amount = s_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

    assign mul_full  = mul_a * mul_b;
    assign low_bit   = pos_reg & (~pos_reg + PW'(1));
    // positions outside 1..SIZE end an update walk
    assign pos_out   = (pos_reg == '0) || (32'(pos_reg) > 32'(SIZE));
    assign mem_addr  = AW'(32'(pos_reg) - 32'd1);
    assign x_clamped = (32'(x_sel) > 32'(SIZE)) ? PW'(SIZE) : PW'(x_sel);
    assign prefix    = prod_reg + acc_c_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        amount_next    = amount_reg;
        pos_next       = pos_reg;
        cx_next        = cx_reg;
        delta_b_next   = delta_b_reg;
        delta_c_next   = delta_c_reg;
        acc_b_next     = acc_b_reg;
        acc_c_next     = acc_c_reg;
        prod_next      = prod_reg;
        pre_next       = pre_reg;
        out_data_next  = out_data_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = mem_addr;
        mem_wr_b    = rd_b_reg + delta_b_reg;
        mem_wr_c    = rd_c_reg + delta_c_reg;
        mul_a       = '0;
        mul_b       = '0;
        x_sel       = in_last;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_b    = '0;
                mem_wr_c    = '0;
                if (32'(clr_reg) == 32'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // a zero first index counts as one
                    first_next  = (in_first == '0) ? IDX_W'(1) : in_first;
                    last_next   = in_last;
                    amount_next = in_amount;
                    phase_next  = 1'b0;
                    cx_next     = x_clamped;
                    pos_next    = x_clamped;
                    acc_b_next  = '0;
                    acc_c_next  = '0;
                    if (s_axis_tuser[0] == CMD_ADD)
                    begin
                        state_next = ST_ADD_MUL;
                    end
                    else
                    begin
                        state_next = ST_Q_RD;
                    end
                end
            end

            ST_ADD_MUL:
            begin
                if (!phase_reg)
                begin
                    mul_a        = 32'(first_reg - IDX_W'(1));
                    mul_b        = ~amount_reg + 32'd1;
                    delta_b_next = amount_reg;
                    pos_next     = PW'(first_reg);
                end
                else
                begin
                    mul_a        = 32'(last_reg);
                    mul_b        = amount_reg;
                    delta_b_next = ~amount_reg + 32'd1;
                    pos_next     = PW'(last_reg) + PW'(1);
                end
                delta_c_next = mul_full[DATA_W-1:0];
                state_next   = ST_POST_RD;
            end

            ST_POST_RD:
            begin
                if (pos_out)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        state_next = ST_ADD_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_POST_WR;
                end
            end

            ST_POST_WR:
            begin
                mem_wr_en  = 1'b1;
                pos_next   = pos_reg + low_bit;
                state_next = ST_POST_RD;
            end

            ST_Q_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_Q_MUL;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_Q_ACC;
                end
            end

            ST_Q_ACC:
            begin
                acc_b_next = acc_b_reg + rd_b_reg;
                acc_c_next = acc_c_reg + rd_c_reg;
                pos_next   = pos_reg - low_bit;
                state_next = ST_Q_RD;
            end

            ST_Q_MUL:
            begin
                mul_a      = acc_b_reg;
                mul_b      = 32'(cx_reg);
                prod_next  = mul_full[DATA_W-1:0];
                state_next = ST_Q_SUM;
            end

            ST_Q_SUM:
            begin
                x_sel = first_reg - IDX_W'(1);
                if (!phase_reg)
                begin
                    pre_next   = prefix;
                    phase_next = 1'b1;
                    cx_next    = x_clamped;
                    pos_next   = x_clamped;
                    acc_b_next = '0;
                    acc_c_next = '0;
                    state_next = ST_Q_RD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pre_reg - prefix;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        last_reg     <= last_next;
        amount_reg   <= amount_next;
        pos_reg      <= pos_next;
        cx_reg       <= cx_next;
        delta_b_reg  <= delta_b_next;
        delta_c_reg  <= delta_c_next;
        acc_b_reg    <= acc_b_next;
        acc_c_reg    <= acc_c_next;
        prod_reg     <= prod_next;
        pre_reg      <= pre_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            base_mem[mem_wr_addr] <= mem_wr_b;
            corr_mem[mem_wr_addr] <= mem_wr_c;
        end
        if (mem_rd_en)
        begin
            rd_b_reg <= base_mem[mem_addr];
            rd_c_reg <= corr_mem[mem_addr];
        end
    end

`ifndef SYNTH
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_add_starts_multiply: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tuser[0] == CMD_ADD) |=> (state_reg == ST_ADD_MUL))
        else $error("add command did not start with delta multiply");

    a_sum_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tuser[0] == CMD_SUM) |=> (state_reg == ST_Q_RD))
        else $error("sum command did not start a prefix walk");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST_WR) |-> (pos_reg != '0 && 32'(pos_reg) <= 32'(SIZE)))
        else $error("tree update outside 1..SIZE");

    a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_Q_SUM && $past(phase_reg)))
        else $error("result raised outside final sum step");
`endif

endmodule

`default_nettype wire
